### sv/rpa_pkg.sv
`default_nettype none

package rpa_pkg;

  // Field widths
  localparam int PAGE_W   = 15;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;

  // Number of page indices the page field can name
  localparam int PAGE_SPAN = 1 << PAGE_W;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Operation codes
  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_ADDREF  = 2'd2;
  localparam op_t OP_RESOLVE = 2'd3;

  // Result status codes
  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_OOM    = 3'd1;
  localparam status_t ST_BAD    = 3'd2;
  localparam status_t ST_KEPT   = 3'd3;
  localparam status_t ST_DOUBLE = 3'd4;

  localparam count_t COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_FIX
  } rpa_state_t;

endpackage

`default_nettype wire

### sv/rpa_req_if.sv
`default_nettype none

interface rpa_req_if;
  logic            valid;
  logic            ready;
  rpa_pkg::op_t    op;
  rpa_pkg::page_t  page;

  modport source (output valid, output op, output page, input ready);
  modport sink   (input valid, input op, input page, output ready);
endinterface

`default_nettype wire

### sv/rpa_rsp_if.sv
`default_nettype none

interface rpa_rsp_if;
  logic              valid;
  logic              ready;
  rpa_pkg::status_t  status;
  rpa_pkg::page_t    page_out;
  logic              page_freed;

  modport source (output valid, output status, output page_out, output page_freed,
                  input ready);
  modport sink   (input valid, input status, input page_out, input page_freed,
                  output ready);
endinterface

`default_nettype wire

### sv/refcounted_page_allocator_unit.sv
`default_nettype none

// Channel   Dir  Payload                               Handshake
// -------   ---  ------------------------------------  ----------------
// req       in   op[1:0], page[14:0]                   valid / ready
// rsp       out  status[2:0], page_out[14:0],          valid / ready
//                page_freed
// cfg       in   cfg_wdata[14:0] (first_page)          cfg_we, no wait
//
// A request is taken in S_IDLE, which reads the reference count memory and the
// stack top, then modified and written back in S_EXEC. A resolve that pops a
// fresh page adds S_FIX for the second write through the count memory's one write port.
// Reset and every first_page write start a sweep over all NUM_PAGES entries that
// clears the counts and refills the free stack; no request is taken then.
// A waiting result holds the operation in its write-back cycle.

module refcounted_page_allocator_unit #(
  parameter int NUM_PAGES = 32768
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire rpa_pkg::page_t         cfg_wdata,
  rpa_req_if.sink                     req,
  rpa_rsp_if.source                   rsp
);

  import rpa_pkg::*;

  localparam int AW       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SCW      = $clog2(NUM_PAGES + 1);
  localparam int RC_DEPTH = (NUM_PAGES < PAGE_SPAN) ? NUM_PAGES : PAGE_SPAN;
  localparam int RW       = (RC_DEPTH > 1) ? $clog2(RC_DEPTH) : 1;

  localparam logic [31:0]    NUM_PAGES_W = 32'(NUM_PAGES);
  localparam logic [31:0]    RC_DEPTH_W  = 32'(RC_DEPTH);
  localparam logic [SCW-1:0] SC_FULL     = SCW'(NUM_PAGES);
  localparam logic [AW-1:0]  IDX_LAST    = AW'(NUM_PAGES - 1);

  // Control state
  rpa_state_t     state, state_next;
  logic [AW-1:0]  idx, idx_next;
  page_t          fp, fp_next;
  logic           rsp_vld, rsp_vld_next;

  // Datapath registers
  logic [SCW-1:0] sc, sc_next;
  op_t            op_r, op_r_next;
  page_t          pg_r, pg_r_next;
  count_t         fix, fix_next;
  status_t        status_r, status_r_next;
  page_t          pout_r, pout_r_next;
  logic           freed_r, freed_r_next;

  // Memory ports
  logic           rc_we, st_we, mem_re;
  logic [RW-1:0]  rc_waddr, rc_raddr;
  count_t         rc_wdata, rc_rdata;
  logic [AW-1:0]  st_waddr, st_raddr;
  page_t          st_wdata, st_rdata;

  // Helpers
  logic [SCW-1:0]       sc_m1;
  logic [SCW-1:0]       sc_init;
  logic [31:0]          sc_init_full;
  logic [AW+PAGE_W-1:0] idx_wide;
  logic                 in_rng;
  logic                 go;

  rpa_ram #(.WIDTH(COUNT_W), .DEPTH(RC_DEPTH)) u_counts (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .re    (mem_re),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

  rpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (mem_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Stack count after a refill, and address helpers
  assign sc_init_full = NUM_PAGES_W - 32'(fp);
  assign sc_init  = (32'(fp) < NUM_PAGES_W) ? SCW'(sc_init_full) : '0;
  assign sc_m1    = sc - 1'b1;
  assign idx_wide = {{PAGE_W{1'b0}}, idx};
  assign in_rng   = (pg_r >= fp) && (32'(pg_r) < NUM_PAGES_W);
  assign go       = !rsp_vld || rsp.ready;

  // Read addresses: count of the requested page, and the stack top
  assign rc_raddr = req.page[RW-1:0];
  assign st_raddr = sc_m1[AW-1:0];

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_vld;
  assign rsp.status     = status_r;
  assign rsp.page_out   = pout_r;
  assign rsp.page_freed = freed_r;

  // Next state, memory writes and results
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    fp_next       = fp;
    sc_next       = sc;
    op_r_next     = op_r;
    pg_r_next     = pg_r;
    fix_next      = fix;
    status_r_next = status_r;
    pout_r_next   = pout_r;
    freed_r_next  = freed_r;
    rsp_vld_next  = rsp_vld && !rsp.ready;
    mem_re        = 1'b0;
    rc_we         = 1'b0;
    rc_waddr      = pg_r[RW-1:0];
    rc_wdata      = '0;
    st_we         = 1'b0;
    st_waddr      = sc[AW-1:0];
    st_wdata      = pg_r;

    unique case (state)
      S_SWEEP: begin
        // Clear one count and refill one stack entry per cycle
        rc_we    = (32'(idx) < RC_DEPTH_W);
        rc_waddr = idx[RW-1:0];
        rc_wdata = '0;
        st_we    = 1'b1;
        st_waddr = idx;
        st_wdata = fp + idx_wide[PAGE_W-1:0];
        sc_next  = sc_init;
        if (idx == IDX_LAST) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_IDLE: begin
        // Take a request and launch both reads
        if (req.valid) begin
          mem_re     = 1'b1;
          op_r_next  = req.op;
          pg_r_next  = req.page;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (go) begin
          status_r_next = ST_OK;
          pout_r_next   = '0;
          freed_r_next  = 1'b0;
          rsp_vld_next  = 1'b1;
          state_next    = S_IDLE;
          if (op_r == OP_ALLOC) begin
            // Pop the top page with a count of one
            if (sc == '0) begin
              status_r_next = ST_OOM;
            end else begin
              sc_next     = sc_m1;
              pout_r_next = st_rdata;
              rc_we       = 1'b1;
              rc_waddr    = st_rdata[RW-1:0];
              rc_wdata    = count_t'(1);
            end
          end else if (!in_rng) begin
            status_r_next = ST_BAD;
          end else begin
            case (op_r)
              OP_RELEASE: begin
                // Drop a reference; push the page when it reaches zero and the stack is not full
                if (rc_rdata == '0) begin
                  status_r_next = ST_DOUBLE;
                end else begin
                  rc_we    = 1'b1;
                  rc_wdata = rc_rdata - 1'b1;
                  if (rc_rdata == count_t'(1) && sc < SC_FULL) begin
                    st_we        = 1'b1;
                    sc_next      = sc + 1'b1;
                    freed_r_next = 1'b1;
                  end
                end
              end
              OP_ADDREF: begin
                // Saturating increment
                if (rc_rdata != COUNT_MAX) begin
                  rc_we    = 1'b1;
                  rc_wdata = rc_rdata + 1'b1;
                end
              end
              default: begin
                // Copy-on-write resolve
                if (rc_rdata == count_t'(1)) begin
                  status_r_next = ST_KEPT;
                end else if (rc_rdata == '0) begin
                  status_r_next = ST_DOUBLE;
                end else if (sc == '0) begin
                  status_r_next = ST_OOM;
                end else begin
                  sc_next     = sc_m1;
                  pout_r_next = st_rdata;
                  rc_we       = 1'b1;
                  rc_waddr    = st_rdata[RW-1:0];
                  rc_wdata    = count_t'(1);
                  // Old page loses a reference next cycle; it may be the fresh page
                  fix_next    = (st_rdata == pg_r) ? '0 : rc_rdata - 1'b1;
                  state_next  = S_FIX;
                end
              end
            endcase
          end
        end
      end

      S_FIX: begin
        // Write back the old page's decremented count
        rc_we      = 1'b1;
        rc_waddr   = pg_r[RW-1:0];
        rc_wdata   = fix;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_SWEEP;
      end
    endcase

    // A first_page write restarts the refill
    if (cfg_we) begin
      fp_next    = cfg_wdata;
      idx_next   = '0;
      state_next = S_SWEEP;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      idx     <= '0;
      fp      <= '0;
      rsp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      fp      <= fp_next;
      rsp_vld <= rsp_vld_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    sc       <= sc_next;
    op_r     <= op_r_next;
    pg_r     <= pg_r_next;
    fix      <= fix_next;
    status_r <= status_r_next;
    pout_r   <= pout_r_next;
    freed_r  <= freed_r_next;
  end

endmodule

`default_nettype wire

### sv/rpa_ram.sv
`default_nettype none

module rpa_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32768,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### test/refcounted_page_allocator_unit_tb.sv
`timescale 1ns / 100ps

module refcounted_page_allocator_unit_tb;
  import rpa_pkg::*;

  localparam int TB_PAGES    = 32768;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    status_t status;
    page_t   page_out;
    logic    page_freed;
  } alloc_result_t;

  // Track free stack and reference counts; queue the expected response per request
  class page_alloc_scoreboard;
    page_t         free_stack [TB_PAGES];
    count_t        ref_count  [TB_PAGES];
    int            stack_depth;
    int            first_page;
    alloc_result_t expected_results [$];
    int            errors;

    function new();
      errors = 0;
      reinit(0);
    endfunction

    // Clear counts and refill the stack from first_page upward
    function void reinit(int fp);
      first_page  = fp;
      stack_depth = 0;
      foreach (ref_count[i]) ref_count[i] = '0;
      for (int p = fp; p < TB_PAGES; p++) begin
        free_stack[stack_depth] = page_t'(p);
        stack_depth++;
      end
    endfunction

    function bit pop_free(output page_t p);
      p = '0;
      if (stack_depth == 0) return 1'b0;
      stack_depth--;
      p = free_stack[stack_depth];
      ref_count[p] = 8'd1;
      return 1'b1;
    endfunction

    function bit push_free(page_t p);
      if (stack_depth >= TB_PAGES) return 1'b0;
      free_stack[stack_depth] = p;
      stack_depth++;
      return 1'b1;
    endfunction

    function alloc_result_t predict_response(op_t op, page_t pg);
      alloc_result_t r;
      page_t         np;
      r.status     = ST_OK;
      r.page_out   = '0;
      r.page_freed = 1'b0;
      if (op == OP_ALLOC) begin
        if (pop_free(np)) r.page_out = np;
        else r.status = ST_OOM;
      end else if (int'(pg) < first_page || int'(pg) >= TB_PAGES) begin
        r.status = ST_BAD;
      end else if (op == OP_RELEASE) begin
        if (ref_count[pg] == 0) begin
          r.status = ST_DOUBLE;
        end else begin
          ref_count[pg] = ref_count[pg] - 8'd1;
          if (ref_count[pg] == 0 && push_free(pg)) r.page_freed = 1'b1;
        end
      end else if (op == OP_ADDREF) begin
        if (ref_count[pg] != COUNT_MAX) ref_count[pg] = ref_count[pg] + 8'd1;
      end else begin
        // Resolve: keep a sole owner, else hand out a fresh page
        if (ref_count[pg] == 8'd1) begin
          r.status = ST_KEPT;
        end else if (ref_count[pg] == 0) begin
          r.status = ST_DOUBLE;
        end else if (!pop_free(np)) begin
          r.status = ST_OOM;
        end else begin
          r.page_out    = np;
          ref_count[pg] = ref_count[pg] - 8'd1;
        end
      end
      return r;
    endfunction

    function void note_request(op_t op, page_t pg);
      expected_results.push_back(predict_response(op, pg));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_result(status_t st, page_t po, logic pf);
      alloc_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t ERROR unexpected response: status %0d page_out %0d page_freed %0d",
                 $time, st, po, pf);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (st !== exp.status) begin
        $display("%0t ERROR status: expected %0d, got %0d", $time, exp.status, st);
        errors++;
      end
      if (po !== exp.page_out) begin
        $display("%0t ERROR page_out: expected %0d, got %0d", $time, exp.page_out, po);
        errors++;
      end
      if (pf !== exp.page_freed) begin
        $display("%0t ERROR page_freed: expected %0d, got %0d", $time, exp.page_freed, pf);
        errors++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  cfg_we;
  page_t cfg_wdata;

  rpa_req_if req_ch ();
  rpa_rsp_if rsp_ch ();

  page_alloc_scoreboard sb;

  int first_page_cfg;
  int send_idle_pct;
  int recv_idle_pct;
  int long_hold_pending;
  int hold_left;
  int cycle_count;

  refcounted_page_allocator_unit #(
    .NUM_PAGES(TB_PAGES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check responses and drive ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.status, rsp_ch.page_out, rsp_ch.page_freed);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (long_hold_pending != 0) begin
        long_hold_pending = 0;
        hold_left = LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random; hold until accepted
  task automatic send_request(op_t op, page_t pg);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.page  <= pg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, pg);
  endtask

  // Mostly live pages near the top of the pool, some out of range, some noise
  task automatic send_random_request();
    int    sel;
    int    lo;
    op_t   op;
    page_t pg;
    sel = $urandom_range(99);
    if (sel < 30) op = OP_ALLOC;
    else if (sel < 58) op = OP_RELEASE;
    else if (sel < 78) op = OP_ADDREF;
    else op = OP_RESOLVE;
    lo  = (first_page_cfg > TB_PAGES - 64) ? first_page_cfg : TB_PAGES - 64;
    sel = $urandom_range(99);
    if (sel < 80) pg = page_t'($urandom_range(TB_PAGES - 1, lo));
    else if (sel < 90 && first_page_cfg > 0) pg = page_t'($urandom_range(first_page_cfg - 1, 0));
    else pg = page_t'($urandom);
    send_request(op, pg);
  endtask

  // Drop valid and drain every outstanding response
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_first_page(int value);
    cfg_wdata <= page_t'(value);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.reinit(value);
    first_page_cfg = value;
  endtask

  initial begin
    sb                = new();
    first_page_cfg    = 0;
    send_idle_pct     = 10;
    recv_idle_pct     = 46;
    long_hold_pending = 0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_ALLOC;
    req_ch.page       = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Full pool: dropped push on a full stack, double release, keep and copy
    send_request(OP_ADDREF,  15'd100);
    send_request(OP_RELEASE, 15'd100);
    send_request(OP_RELEASE, 15'd100);
    send_request(OP_RESOLVE, 15'd100);
    send_request(OP_ALLOC,   15'd0);
    send_request(OP_ALLOC,   15'd0);
    send_request(OP_RESOLVE, 15'd32767);
    send_request(OP_ADDREF,  15'd32767);
    send_request(OP_RESOLVE, 15'd32767);
    send_request(OP_RELEASE, 15'd32767);
    send_request(OP_ALLOC,   15'h7fff);
    send_request(OP_RELEASE, 15'd32765);
    send_request(OP_RELEASE, 15'd32767);
    send_request(OP_RELEASE, 15'd32766);
    send_request(OP_ADDREF,  15'd0);
    drain();

    // Single-page pool: out of memory, bad pages, resolve without a free page
    write_first_page(32767);
    send_request(OP_ALLOC,   15'd0);
    send_request(OP_ALLOC,   15'd0);
    send_request(OP_RELEASE, 15'd0);
    send_request(OP_ADDREF,  15'd32766);
    send_request(OP_RESOLVE, 15'd16384);
    send_request(OP_ADDREF,  15'd32767);
    send_request(OP_RESOLVE, 15'd32767);
    send_request(OP_RELEASE, 15'd32767);
    send_request(OP_RELEASE, 15'd32767);
    send_request(OP_RELEASE, 15'd32767);
    drain();

    // Small pool, sender idles lightly: long response hold-off and count saturation
    write_first_page(32736);
    for (int i = 0; i < 520; i++) begin
      if (i == 100) long_hold_pending = 1;
      if (i >= 200 && i < 458) send_request(OP_ADDREF, 15'd32767);
      else send_random_request();
    end
    drain();

    // Smaller pool, receiver idles lightly: pause mid-phase until drained
    send_idle_pct = 46;
    recv_idle_pct = 10;
    write_first_page(32752);
    for (int i = 0; i < 520; i++) begin
      if (i == 260) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random_request();
    end
    drain();

    // Whole pool again, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_first_page(0);
    for (int i = 0; i < 520; i++) send_random_request();
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
